/* sv/altitude_hold_pitch_controller_unit_assert.svh */
// Assertion macros shared by the altitude-hold checker.
`ifndef ALTITUDE_HOLD_PITCH_CONTROLLER_UNIT_ASSERT_SVH
`define ALTITUDE_HOLD_PITCH_CONTROLLER_UNIT_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define AHPC_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ahpc assertion failed");

// Consequent checked in the cycle after the antecedent.
`define AHPC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ahpc assertion failed");

`endif

/* sv/ahpc_pkg.sv */
// Types and constants of the altitude-hold pitch controller.
package ahpc_pkg;

   typedef logic signed [19:0] alt_type;
   typedef logic signed [15:0] ang_type;
   typedef logic [15:0]        gain_type;
   typedef logic [19:0]        step_type;
   typedef logic signed [12:0] elev_type;
   typedef logic [2:0]         reg_index_type;

   localparam reg_index_type REG_ALT_GAIN   = 3'd0;
   localparam reg_index_type REG_PITCH_GAIN = 3'd1;
   localparam reg_index_type REG_RATE_GAIN  = 3'd2;
   localparam reg_index_type REG_STEP_TIME  = 3'd3;
   localparam reg_index_type REG_ALT_TARGET = 3'd4;

   localparam int ALT_LOW     = -6400;
   localparam int ALT_HIGH    = 384000;
   localparam int PITCH_BAND  = 4096;
   localparam int RATE_BAND   = 3686;
   localparam int INTEG_LIMIT = 3932160;
   localparam int CMD_LIMIT   = 1787;
   localparam int ELEV_LIMIT  = 2144;

   localparam int INTEG_DIV   = 3750000;
   localparam int CMD_DIV     = 288000000;
   localparam int RAD_SCALE   = 314159;

   // floor(2^52 / INTEG_DIV) and floor(2^59 / CMD_DIV)
   localparam int INTEG_RECIP = 1200959900;
   localparam int CMD_RECIP   = 2001599834;

   // quotients at or above these always end up clamped
   localparam int     INTEG_SAT_Q = 7864321;
   localparam int     CMD_SAT_Q   = 1788;
   localparam longint INTEG_SAT_X = longint'(INTEG_SAT_Q) * INTEG_DIV;
   localparam longint CMD_SAT_X   = longint'(CMD_SAT_Q) * CMD_DIV;

   localparam gain_type RST_ALT_GAIN   = 16'd128;
   localparam gain_type RST_PITCH_GAIN = 16'd12288;
   localparam gain_type RST_RATE_GAIN  = 16'd2048;
   localparam step_type RST_STEP_TIME  = 20'd20000;
   localparam alt_type  RST_ALT_TARGET = 20'sd6400;

endpackage

/* sv/ahpc_if.sv */
// Sample and command channel interfaces of the altitude-hold pitch controller.
interface ahpc_req_if import ahpc_pkg::*; ();
   logic    valid;
   logic    ready;
   alt_type altitude;
   ang_type pitch_angle;
   ang_type pitch_rate;

   modport source (output valid, output altitude, output pitch_angle, output pitch_rate,
                   input ready);
   modport sink   (input valid, input altitude, input pitch_angle, input pitch_rate,
                   output ready);
endinterface

interface ahpc_rsp_if import ahpc_pkg::*; ();
   logic     valid;
   logic     ready;
   elev_type elevator;
   logic     limited;

   modport source (output valid, output elevator, output limited, input ready);
   modport sink   (input valid, input elevator, input limited, output ready);
endinterface

/* sv/altitude_hold_pitch_controller_unit.sv */
// Altitude-hold pitch controller: sequencer around one shared multiply-accumulate unit.
//
// Usage:
//   req_ch carries one sample (altitude, pitch angle, pitch rate) per transfer;
//   rsp_ch returns one elevator command and its clamp flag per sample.
//   Gains, step time and target altitude sit in an APB register file at
//   byte addresses 0, 4, 8, 12 and 16; write them only while the block is idle.
// Timing:
//   A sample occupies the block from the accepting edge until S_FINISH hands its
//   result to the output register; rsp_ch.valid rises as the block returns to idle.
//   Both rounded divisions (integrator increment and degree-to-radian scaling) go
//   through three steps: load and saturate, reciprocal multiply, one correction
//   step. All eleven products go through the single 33x33 signed multiplier, one
//   per cycle. req_ch.ready is high only in idle.
// Reset:
//   Registers return to their default values; integrator and held readings
//   clear to zero; no result is pending.
// Stall:
//   A result waits in the output register until rsp_ch.ready; the next sample
//   is taken meanwhile, but its result stays in the final step until the slot frees.
module altitude_hold_pitch_controller_unit import ahpc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   ahpc_req_if.sink    req_ch,
   ahpc_rsp_if.source  rsp_ch,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   typedef enum logic [3:0] {
      S_IDLE, S_MUL_ERR, S_MUL_LO, S_MUL_HI, S_DIV_LOAD, S_DIV_EST, S_DIV_FIX, S_INTEG,
      S_CMD, S_SCALE_LO, S_SCALE_HI, S_LIMIT, S_MUL_RATE, S_MUL_PITCH, S_FINISH
   } state_type;

   gain_type alt_gain_ff, pitch_gain_ff, rate_gain_ff;
   step_type step_time_ff;
   alt_type  alt_target_ff;

   state_type          state_ff, state_in;
   alt_type            held_alt_ff, held_alt_in;
   ang_type            held_pitch_ff, held_pitch_in;
   ang_type            held_rate_ff, held_rate_in;
   step_type           held_step_ff, held_step_in;
   logic signed [22:0] integ_ff, integ_in;
   logic signed [20:0] err_ff, err_in;
   logic signed [39:0] prod_ff, prod_in;
   logic signed [59:0] acc_ff, acc_in;
   logic [44:0]        xnum_ff, xnum_in;
   logic [22:0]        quo_ff, quo_in;
   logic               sat_ff, sat_in;
   logic               neg_ff, neg_in;
   logic               phase_ff, phase_in;
   logic signed [13:0] pe_ff, pe_in;
   logic               rsp_valid_ff, rsp_valid_in;
   elev_type           rsp_elev_ff, rsp_elev_in;
   logic               rsp_lim_ff, rsp_lim_in;

   logic               cfg_write;
   reg_index_type      cfg_index;

   logic               req_take;
   alt_type            alt_sel;
   ang_type            pitch_sel, rate_sel;
   step_type           step_sel;

   logic signed [32:0] mul_a;
   logic [31:0]        mul_b;
   logic               mul_hi, mul_clear;
   logic signed [65:0] mul_prod;
   logic signed [59:0] mul_ext, mul_term, acc_sum;
   logic signed [15:0] prod_hi;

   logic [59:0]        mag;
   logic [59:0]        num_full;
   logic [59:0]        sat_x;
   logic [28:0]        div_d;
   logic [30:0]        recip;
   logic [28:0]        x_top;
   logic [22:0]        q_est;
   logic [44:0]        rfix;

   logic signed [39:0] quot, inc;
   logic signed [40:0] isum;
   logic [10:0]        cmag;
   logic signed [11:0] cmdc;

   logic signed [31:0] pval;
   logic [31:0]        pmag, prnd;
   logic [19:0]        rq;
   logic               elim;
   logic [11:0]        emag;
   elev_type           elev;

   // Register file
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;
   assign cfg_index = paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         alt_gain_ff   <= RST_ALT_GAIN;
         pitch_gain_ff <= RST_PITCH_GAIN;
         rate_gain_ff  <= RST_RATE_GAIN;
         step_time_ff  <= RST_STEP_TIME;
         alt_target_ff <= RST_ALT_TARGET;
      end else if (cfg_write) begin
         unique case (cfg_index)
            REG_ALT_GAIN:   alt_gain_ff   <= pwdata[15:0];
            REG_PITCH_GAIN: pitch_gain_ff <= pwdata[15:0];
            REG_RATE_GAIN:  rate_gain_ff  <= pwdata[15:0];
            REG_STEP_TIME:  step_time_ff  <= pwdata[19:0];
            REG_ALT_TARGET: alt_target_ff <= $signed(pwdata[19:0]);
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (cfg_index)
         REG_ALT_GAIN:   prdata = {16'd0, alt_gain_ff};
         REG_PITCH_GAIN: prdata = {16'd0, pitch_gain_ff};
         REG_RATE_GAIN:  prdata = {16'd0, rate_gain_ff};
         REG_STEP_TIME:  prdata = {12'd0, step_time_ff};
         REG_ALT_TARGET: prdata = {12'd0, alt_target_ff};
         default:        prdata = 32'd0;
      endcase
   end

   // Channels
   assign req_ch.ready    = (state_ff == S_IDLE);
   assign req_take        = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.elevator = rsp_elev_ff;
   assign rsp_ch.limited  = rsp_lim_ff;

   // Replace out-of-band readings, and a zero step time, by the held ones
   always_comb begin
      alt_sel = req_ch.altitude;
      if (req_ch.altitude > ALT_HIGH || req_ch.altitude < ALT_LOW) alt_sel = held_alt_ff;
      pitch_sel = req_ch.pitch_angle;
      if (req_ch.pitch_angle > PITCH_BAND || req_ch.pitch_angle < -PITCH_BAND)
         pitch_sel = held_pitch_ff;
      rate_sel = req_ch.pitch_rate;
      if (req_ch.pitch_rate > RATE_BAND || req_ch.pitch_rate < -RATE_BAND)
         rate_sel = held_rate_ff;
      step_sel = (step_time_ff == 20'd0) ? held_step_ff : step_time_ff;
   end

   // Shared multiply-accumulate unit
   assign prod_hi = prod_ff[39:24];

   always_comb begin
      mul_a     = 33'sd0;
      mul_b     = 32'd0;
      mul_hi    = 1'b0;
      mul_clear = 1'b1;
      unique case (state_ff)
         S_MUL_ERR: begin
            mul_a = 33'(err_ff);
            mul_b = 32'(alt_gain_ff);
         end
         S_MUL_LO: begin
            mul_a = $signed({9'd0, acc_ff[23:0]});
            mul_b = 32'(held_step_ff);
         end
         S_MUL_HI: begin
            mul_a     = 33'(prod_hi);
            mul_b     = 32'(held_step_ff);
            mul_hi    = 1'b1;
            mul_clear = 1'b0;
         end
         S_DIV_EST: begin
            mul_a = $signed({4'd0, x_top});
            mul_b = 32'(recip);
         end
         S_DIV_FIX: begin
            mul_a = $signed({10'd0, quo_ff});
            mul_b = 32'(div_d);
         end
         S_SCALE_LO: begin
            mul_a = $signed({9'd0, prod_ff[23:0]});
            mul_b = 32'(RAD_SCALE);
         end
         S_SCALE_HI: begin
            mul_a     = 33'(prod_hi);
            mul_b     = 32'(RAD_SCALE);
            mul_hi    = 1'b1;
            mul_clear = 1'b0;
         end
         S_MUL_RATE: begin
            mul_a = 33'(held_rate_ff);
            mul_b = 32'(rate_gain_ff);
         end
         S_MUL_PITCH: begin
            mul_a     = 33'(pe_ff);
            mul_b     = 32'(pitch_gain_ff);
            mul_clear = 1'b0;
         end
         default: ;
      endcase
   end

   assign mul_prod = mul_a * $signed({1'b0, mul_b});
   assign mul_ext  = 60'(mul_prod);
   assign mul_term = mul_hi ? $signed({mul_ext[35:0], 24'd0}) : mul_ext;
   assign acc_sum  = (mul_clear ? 60'sd0 : acc_ff) + mul_term;

   // Rounding divider
   assign mag      = acc_ff[59] ? 60'(-acc_ff) : 60'(acc_ff);
   assign div_d    = phase_ff ? 29'(CMD_DIV) : 29'(INTEG_DIV);
   assign recip    = phase_ff ? 31'(CMD_RECIP) : 31'(INTEG_RECIP);
   assign num_full = mag + (phase_ff ? 60'(CMD_DIV / 2) : 60'(INTEG_DIV / 2));
   assign sat_x    = phase_ff ? 60'(CMD_SAT_X) : 60'(INTEG_SAT_X);
   assign x_top    = phase_ff ? xnum_ff[38:10] : xnum_ff[44:16];
   assign q_est    = phase_ff ? 23'(mul_prod[59:49]) : mul_prod[58:36];
   assign rfix     = xnum_ff - mul_prod[44:0];

   // Integrator and pitch command
   assign quot = $signed(40'(quo_ff));
   assign inc  = neg_ff ? -quot : quot;
   assign isum = 41'(inc) + 41'(integ_ff);
   assign cmag = (quo_ff > 23'(CMD_LIMIT)) ? 11'(CMD_LIMIT) : quo_ff[10:0];
   assign cmdc = neg_ff ? -$signed({1'b0, cmag}) : $signed({1'b0, cmag});

   // Elevator rounding and clamp
   assign pval = $signed(acc_ff[31:0]);
   assign pmag = pval[31] ? 32'(-pval) : 32'(pval);
   assign prnd = pmag + 32'd2048;
   assign rq   = prnd[31:12];
   assign elim = rq > 20'(ELEV_LIMIT);
   assign emag = elim ? 12'(ELEV_LIMIT) : rq[11:0];
   assign elev = pval[31] ? -$signed({1'b0, emag}) : $signed({1'b0, emag});

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      held_alt_in   = held_alt_ff;
      held_pitch_in = held_pitch_ff;
      held_rate_in  = held_rate_ff;
      held_step_in  = held_step_ff;
      integ_in      = integ_ff;
      err_in        = err_ff;
      prod_in       = prod_ff;
      acc_in        = acc_ff;
      xnum_in       = xnum_ff;
      quo_in        = quo_ff;
      sat_in        = sat_ff;
      neg_in        = neg_ff;
      phase_in      = phase_ff;
      pe_in         = pe_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_elev_in   = rsp_elev_ff;
      rsp_lim_in    = rsp_lim_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               held_alt_in   = alt_sel;
               held_pitch_in = pitch_sel;
               held_rate_in  = rate_sel;
               held_step_in  = step_sel;
               err_in        = 21'(alt_target_ff) - 21'(alt_sel);
               phase_in      = 1'b0;
               state_in      = S_MUL_ERR;
            end
         end
         S_MUL_ERR: begin
            acc_in   = acc_sum;
            state_in = S_MUL_LO;
         end
         S_MUL_LO: begin
            prod_in  = acc_ff[39:0];
            acc_in   = acc_sum;
            state_in = S_MUL_HI;
         end
         S_MUL_HI: begin
            acc_in   = acc_sum;
            state_in = S_DIV_LOAD;
         end
         S_DIV_LOAD: begin
            xnum_in  = num_full[44:0];
            sat_in   = num_full >= sat_x;
            neg_in   = acc_ff[59];
            state_in = S_DIV_EST;
         end
         S_DIV_EST: begin
            quo_in   = q_est;
            state_in = S_DIV_FIX;
         end
         S_DIV_FIX: begin
            if (sat_ff) begin
               quo_in = phase_ff ? 23'(CMD_SAT_Q) : 23'(INTEG_SAT_Q);
            end else if (rfix >= 45'(div_d)) begin
               quo_in = quo_ff + 23'd1;
            end
            state_in = phase_ff ? S_LIMIT : S_INTEG;
         end
         S_INTEG: begin
            if (isum > INTEG_LIMIT) begin
               integ_in = 23'(INTEG_LIMIT);
            end else if (isum < -INTEG_LIMIT) begin
               integ_in = 23'(-INTEG_LIMIT);
            end else begin
               integ_in = isum[22:0];
            end
            state_in = S_CMD;
         end
         S_CMD: begin
            prod_in  = $signed({prod_ff[37:0], 2'b00}) + 40'(integ_ff);
            phase_in = 1'b1;
            state_in = S_SCALE_LO;
         end
         S_SCALE_LO: begin
            acc_in   = acc_sum;
            state_in = S_SCALE_HI;
         end
         S_SCALE_HI: begin
            acc_in   = acc_sum;
            state_in = S_DIV_LOAD;
         end
         S_LIMIT: begin
            pe_in    = 14'(held_pitch_ff) - 14'(cmdc);
            state_in = S_MUL_RATE;
         end
         S_MUL_RATE: begin
            acc_in   = acc_sum;
            state_in = S_MUL_PITCH;
         end
         S_MUL_PITCH: begin
            acc_in   = acc_sum;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_elev_in  = elev;
               rsp_lim_in   = elim;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         held_alt_ff   <= '0;
         held_pitch_ff <= '0;
         held_rate_ff  <= '0;
         held_step_ff  <= '0;
         integ_ff      <= '0;
         phase_ff      <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         held_alt_ff   <= held_alt_in;
         held_pitch_ff <= held_pitch_in;
         held_rate_ff  <= held_rate_in;
         held_step_ff  <= held_step_in;
         integ_ff      <= integ_in;
         phase_ff      <= phase_in;
         err_ff        <= err_in;
         prod_ff       <= prod_in;
         acc_ff        <= acc_in;
         xnum_ff       <= xnum_in;
         quo_ff        <= quo_in;
         sat_ff        <= sat_in;
         neg_ff        <= neg_in;
         pe_ff         <= pe_in;
         rsp_elev_ff   <= rsp_elev_in;
         rsp_lim_ff    <= rsp_lim_in;
      end
   end

endmodule

/* sv/ahpc_checker.sv */
// Port-level assertion checker of the altitude-hold pitch controller, bound to the top level.
`include "altitude_hold_pitch_controller_unit_assert.svh"

module ahpc_checker import ahpc_pkg::*; (
   input logic     clock,
   input logic     reset,
   input logic     req_valid,
   input logic     req_ready,
   input logic     rsp_valid,
   input logic     rsp_ready,
   input elev_type elevator,
   input logic     limited
);

   `AHPC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(elevator) && $stable(limited))
   `AHPC_ASSERT_SAME(a_elev_range, rsp_valid, elevator <= 13'sd2144 && elevator >= -13'sd2144)
   `AHPC_ASSERT_SAME(a_limit_sat, rsp_valid && limited, elevator == 13'sd2144 || elevator == -13'sd2144)
   `AHPC_ASSERT_NEXT(a_busy_after_take, req_valid && req_ready, !req_ready)

endmodule

bind altitude_hold_pitch_controller_unit ahpc_checker u_ahpc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .elevator  (rsp_ch.elevator),
   .limited   (rsp_ch.limited)
);

/* tb/tb.sv */
// Self-checking testbench of the altitude-hold pitch controller unit.
`timescale 1ns / 1ps

module tb;
   import ahpc_pkg::*;

   typedef struct packed {
      alt_type altitude;
      ang_type pitch_angle;
      ang_type pitch_rate;
   } sample_type;

   typedef struct packed {
      elev_type elevator;
      logic     limited;
   } command_type;

   localparam reg_index_type REG_UNUSED_FIRST = REG_ALT_TARGET + 3'd1;
   localparam reg_index_type REG_UNUSED_LAST  = 3'd7;
   localparam longint        ELEV_SCALE       = 4096;
   localparam int            SETTLE_CYCLES    = 100;

   logic        clock;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [4:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   ahpc_req_if req_ch ();
   ahpc_rsp_if rsp_ch ();

   altitude_hold_pitch_controller_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // predictor registers and state
   longint cfg_alt_gain;
   longint cfg_pitch_gain;
   longint cfg_rate_gain;
   longint cfg_step;
   longint cfg_target;
   longint integ_q16;
   longint held_alt;
   longint held_pitch;
   longint held_rate;
   longint held_step;

   sample_type  samples_to_send[$];
   command_type predicted_commands[$];
   sample_type  on_wire;
   command_type next_command;
   int          mismatch_count;
   int          gap_left;
   int          burst_left;
   int          ready_mode;
   int          ready_left;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic longint round_div(longint num, longint den);
      longint mag;
      mag = (num < 0) ? -num : num;
      mag = (mag + den / 2) / den;
      return (num < 0) ? -mag : mag;
   endfunction

   function automatic longint clamp_to(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   function automatic command_type compute_elevator(sample_type s);
      longint      alt;
      longint      th;
      longint      q;
      longint      dt;
      longint      err;
      longint      cmd;
      longint      elev;
      command_type c;
      alt = s.altitude;
      th  = s.pitch_angle;
      q   = s.pitch_rate;
      dt  = cfg_step;
      if (alt > ALT_HIGH || alt < ALT_LOW) alt = held_alt;
      if (th > PITCH_BAND || th < -PITCH_BAND) th = held_pitch;
      if (q > RATE_BAND || q < -RATE_BAND) q = held_rate;
      if (dt == 0) dt = held_step;
      err = cfg_target - alt;
      integ_q16 = clamp_to(integ_q16 + round_div(err * cfg_alt_gain * dt, INTEG_DIV),
                           INTEG_LIMIT);
      cmd = 4 * err * cfg_alt_gain + integ_q16;
      cmd = clamp_to(round_div(cmd * RAD_SCALE, CMD_DIV), CMD_LIMIT);
      elev = round_div(q * cfg_rate_gain - (cmd - th) * cfg_pitch_gain, ELEV_SCALE);
      c.limited  = (elev > ELEV_LIMIT || elev < -ELEV_LIMIT);
      c.elevator = elev_type'(clamp_to(elev, ELEV_LIMIT));
      held_alt   = alt;
      held_pitch = th;
      held_rate  = q;
      held_step  = dt;
      return c;
   endfunction

   function automatic sample_type random_sample();
      sample_type s;
      int         pick;
      int         span;
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
         case ($urandom_range(0, 2))
            0: span = 64;
            1: span = 1024;
            default: span = 32768;
         endcase
         s.altitude = alt_type'(cfg_target + int'($urandom_range(0, 2 * span)) - span);
      end else if (pick < 8) begin
         s.altitude = alt_type'(ALT_LOW + int'($urandom_range(0, ALT_HIGH - ALT_LOW)));
      end else begin
         s.altitude = alt_type'($urandom());
      end
      if ($urandom_range(0, 4) != 0)
         s.pitch_angle = ang_type'(int'($urandom_range(0, 2 * PITCH_BAND)) - PITCH_BAND);
      else
         s.pitch_angle = ang_type'($urandom());
      if ($urandom_range(0, 4) != 0)
         s.pitch_rate = ang_type'(int'($urandom_range(0, 2 * RATE_BAND)) - RATE_BAND);
      else
         s.pitch_rate = ang_type'($urandom());
      return s;
   endfunction

   task automatic push_sample(input int alt, input int th, input int q);
      samples_to_send.push_back('{alt_type'(alt), ang_type'(th), ang_type'(q)});
   endtask

   task automatic push_random(input int count);
      repeat (count) samples_to_send.push_back(random_sample());
   endtask

   // hold until every sample has gone and every command has come back
   task automatic wait_idle();
      do @(negedge clock);
      while (samples_to_send.size() != 0 || req_ch.valid || predicted_commands.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   // entered and left at a rising edge
   task automatic write_reg(input reg_index_type index, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      case (index)
         REG_ALT_GAIN:   cfg_alt_gain   = value[15:0];
         REG_PITCH_GAIN: cfg_pitch_gain = value[15:0];
         REG_RATE_GAIN:  cfg_rate_gain  = value[15:0];
         REG_STEP_TIME:  cfg_step       = value[19:0];
         REG_ALT_TARGET: cfg_target     = alt_type'(value[19:0]);
         default: ;
      endcase
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_settings(input logic [31:0] ag, input logic [31:0] pg,
                                 input logic [31:0] rg, input logic [31:0] st,
                                 input logic [31:0] tgt);
      write_reg(REG_ALT_GAIN, ag);
      write_reg(REG_PITCH_GAIN, pg);
      write_reg(REG_RATE_GAIN, rg);
      write_reg(REG_STEP_TIME, st);
      write_reg(REG_ALT_TARGET, tgt);
   endtask

   // sample driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         gap_left = 0;
         burst_left = 1;
      end else begin
         if (req_ch.valid && req_ch.ready)
            predicted_commands.push_back(compute_elevator(on_wire));
         if (!req_ch.valid || req_ch.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_ch.valid <= 1'b0;
            end else if (samples_to_send.size() > 0) begin
               on_wire = samples_to_send.pop_front();
               req_ch.valid       <= 1'b1;
               req_ch.altitude    <= on_wire.altitude;
               req_ch.pitch_angle <= on_wire.pitch_angle;
               req_ch.pitch_rate  <= on_wire.pitch_rate;
               burst_left--;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 8);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 100);
               end
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // command receiver stall pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         ready_mode = 0;
         ready_left = 0;
      end else begin
         if (ready_left == 0) begin
            ready_mode = $urandom_range(0, 3);
            ready_left = $urandom_range(1, 120);
         end else begin
            ready_left--;
         end
         case (ready_mode)
            2: rsp_ch.ready <= 1'b0;
            3: rsp_ch.ready <= $urandom_range(0, 1);
            default: rsp_ch.ready <= 1'b1;
         endcase
      end
   end

   // command monitor
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (predicted_commands.size() == 0) begin
            $error("unexpected command transfer: elevator %0d limited %0d",
                   rsp_ch.elevator, rsp_ch.limited);
            mismatch_count++;
         end else begin
            next_command = predicted_commands.pop_front();
            if (rsp_ch.elevator !== next_command.elevator) begin
               $error("elevator: expected %0d, got %0d", next_command.elevator,
                      rsp_ch.elevator);
               mismatch_count++;
            end
            if (rsp_ch.limited !== next_command.limited) begin
               $error("limited: expected %0d, got %0d", next_command.limited,
                      rsp_ch.limited);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      #25000000;
      $display("Mismatches found");
      $finish;
   end

   initial begin
      reset              = 1'b1;
      psel               = 1'b0;
      penable            = 1'b0;
      pwrite             = 1'b0;
      paddr              = '0;
      pwdata             = '0;
      req_ch.valid       = 1'b0;
      req_ch.altitude    = '0;
      req_ch.pitch_angle = '0;
      req_ch.pitch_rate  = '0;
      rsp_ch.ready       = 1'b0;
      mismatch_count     = 0;
      cfg_alt_gain       = RST_ALT_GAIN;
      cfg_pitch_gain     = RST_PITCH_GAIN;
      cfg_rate_gain      = RST_RATE_GAIN;
      cfg_step           = RST_STEP_TIME;
      cfg_target         = RST_ALT_TARGET;
      integ_q16          = 0;
      held_alt           = 0;
      held_pitch         = 0;
      held_rate          = 0;
      held_step          = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero step time before any step was ever taken
      write_reg(REG_STEP_TIME, '0);
      push_sample(0, 0, 0);
      push_sample(RST_ALT_TARGET, 100, -100);
      push_random(1);
      wait_idle();
      write_reg(REG_STEP_TIME, RST_STEP_TIME);

      // band edges and field extremes
      push_sample(ALT_LOW, 0, 0);
      push_sample(ALT_HIGH, 0, 0);
      push_sample(ALT_LOW - 1, 0, 0);
      push_sample(ALT_HIGH + 1, 0, 0);
      push_sample(-524288, 0, 0);
      push_sample(524287, 0, 0);
      push_sample(RST_ALT_TARGET, PITCH_BAND, RATE_BAND);
      push_sample(RST_ALT_TARGET, -PITCH_BAND, -RATE_BAND);
      push_sample(RST_ALT_TARGET, PITCH_BAND + 1, RATE_BAND + 1);
      push_sample(RST_ALT_TARGET, -PITCH_BAND - 1, -RATE_BAND - 1);
      push_sample(RST_ALT_TARGET, -32768, -32768);
      push_sample(RST_ALT_TARGET, 32767, 32767);
      push_sample(RST_ALT_TARGET, 0, 0);
      push_sample(RST_ALT_TARGET + 64, 50, 20);
      push_sample(RST_ALT_TARGET - 64, -50, -20);
      push_sample(0, 0, 0);
      wait_idle();

      // extreme settings; spare addresses must leave the registers alone
      apply_settings('0, '0, '0, '0, '0);
      for (int i = REG_UNUSED_FIRST; i <= REG_UNUSED_LAST; i++)
         write_reg(reg_index_type'(i), $urandom());
      push_random(30);
      wait_idle();
      apply_settings(32'hFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFFF, 32'h7FFFF);
      push_random(30);
      wait_idle();
      apply_settings(32'hFFFF, 32'hFFFF, 32'hFFFF, 1000000, 32'hFFF80000);
      push_random(30);
      wait_idle();
      apply_settings(32'hFFFF, 32'hFFFF, 32'hFFFF, 1, ALT_LOW);
      push_random(30);
      wait_idle();
      apply_settings(RST_ALT_GAIN, RST_PITCH_GAIN, RST_RATE_GAIN, 0, ALT_HIGH);
      push_random(30);
      wait_idle();

      repeat (10) begin
         if ($urandom_range(0, 9) < 7)
            apply_settings($urandom_range(0, 1024), $urandom_range(0, 16384),
                           $urandom_range(0, 8192),
                           ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1000, 100000),
                           ALT_LOW + int'($urandom_range(0, ALT_HIGH - ALT_LOW)));
         else
            apply_settings($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
         push_random(150);
         wait_idle();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && predicted_commands.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

/* altitude_hold_pitch_controller_unit.f */
+incdir+sv
sv/ahpc_pkg.sv
sv/ahpc_if.sv
sv/altitude_hold_pitch_controller_unit.sv
sv/ahpc_checker.sv
tb/tb.sv
